// ===== hdl/csweep_pkg.sv =====
// Shared types, constants and helper functions for the colour sweep generator.
// Used by csweep_cfg, csweep_lcg and color_sweep_pattern_generator.
`timescale 1ns / 1ps
`default_nettype none

package csweep_pkg;

    // Register indexes on the configuration port (word address bit 2)
    localparam logic REG_RAMP_INCR   = 1'b0;
    localparam logic REG_WALK_FRAMES = 1'b1;

    localparam logic [7:0]  RAMP_INCR_RST   = 8'd8;
    localparam logic [15:0] WALK_FRAMES_RST = 16'd256;

    // Phase codes
    localparam logic [2:0] PH_RED  = 3'd0;
    localparam logic [2:0] PH_GREY = 3'd6;
    localparam logic [2:0] PH_WALK = 3'd7;

    // Walk channel select
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [7:0] CHAN_MAX   = 8'd255;
    localparam logic [7:0] WALK_START = 8'd128;

    // Generator constants, multiplier taken one byte per cycle, low byte first
    localparam logic [31:0] LCG_ADD   = 32'd12345;
    localparam logic [31:0] LCG_SEED0 = 32'd12345;
    localparam logic [1:0]  LCG_LAST_DIGIT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0]  ramp_incr;
        logic [15:0] walk_frames;
    } cfg_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [14:0] rnd;
    } lcg_stat_t;

    function automatic logic [7:0] lcg_digit(input logic [1:0] idx);
        logic [7:0] d;
        case (idx)
            2'd0:    d = 8'h6D;
            2'd1:    d = 8'h4E;
            2'd2:    d = 8'hC6;
            2'd3:    d = 8'h41;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

    // Channel enables: bit 2 red, bit 1 green, bit 0 blue
    function automatic logic [2:0] phase_mask(input logic [2:0] ph);
        logic [2:0] m;
        case (ph)
            3'd0:    m = 3'b100;
            3'd1:    m = 3'b010;
            3'd2:    m = 3'b001;
            3'd3:    m = 3'b110;
            3'd4:    m = 3'b101;
            3'd5:    m = 3'b011;
            3'd6:    m = 3'b111;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Remainder by 15: hex digits sum modulo 15 since 16 is 1 mod 15
    function automatic logic [3:0] mod15(input logic [14:0] x);
        logic [5:0] s1;
        logic [4:0] s2;
        s1 = {2'b0, x[3:0]} + {2'b0, x[7:4]} + {2'b0, x[11:8]} + {3'b0, x[14:12]};
        s2 = {3'b0, s1[5:4]} + {1'b0, s1[3:0]};
        if (s2 >= 5'd15)
        begin
            s2 = s2 - 5'd15;
        end
        return s2[3:0];
    endfunction

    // Add (rnd mod 15) - 7 and clamp to 0..255
    function automatic logic [7:0] walk_step(input logic [7:0] v, input logic [14:0] rnd);
        logic [9:0] t;
        logic [7:0] res;
        t = {2'b0, v} + {6'b0, mod15(rnd)};
        if (t < 10'd7)
        begin
            res = 8'd0;
        end
        else if (t > 10'd262)
        begin
            res = CHAN_MAX;
        end
        else
        begin
            t = t - 10'd7;
            res = t[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/csweep_cfg.sv =====
// APB-style register block: sweep step and walk length.
// Depends on csweep_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module csweep_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output csweep_pkg::cfg_t       cfg
);
    import csweep_pkg::*;

    logic [7:0]  step_reg;
    logic [7:0]  step_next;
    logic [15:0] frames_reg;
    logic [15:0] frames_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        step_next   = step_reg;
        frames_next = frames_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_RAMP_INCR:   step_next   = pwdata[7:0];
                REG_WALK_FRAMES: frames_next = pwdata[15:0];
                default:         step_next   = step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_RAMP_INCR:   prdata = {24'd0, step_reg};
            REG_WALK_FRAMES: prdata = {16'd0, frames_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= RAMP_INCR_RST;
            frames_reg <= WALK_FRAMES_RST;
        end
        else
        begin
            step_reg   <= step_next;
            frames_reg <= frames_next;
        end
    end

    assign cfg.ramp_incr   = step_reg;
    assign cfg.walk_frames = frames_reg;

endmodule

`default_nettype wire

// ===== hdl/csweep_lcg.sv =====
// Linear congruential generator, multiplier applied one byte digit per cycle.
// Depends on csweep_pkg for the constants and the status bundle.
`timescale 1ns / 1ps
`default_nettype none

module csweep_lcg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output csweep_pkg::lcg_stat_t   stat
);
    import csweep_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] prod;
    logic [31:0] prod_sh;

    assign prod = seed_reg * {24'd0, lcg_digit(cnt_reg)};

    // Weight the partial product by the digit position
    always_comb
    begin
        case (cnt_reg)
            2'd0:    prod_sh = prod;
            2'd1:    prod_sh = {prod[23:0], 8'd0};
            2'd2:    prod_sh = {prod[15:0], 16'd0};
            2'd3:    prod_sh = {prod[7:0], 24'd0};
            default: prod_sh = prod;
        endcase
    end

    always_comb
    begin
        seed_next = seed_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = LCG_ADD;
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + prod_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == LCG_LAST_DIGIT)
            begin
                seed_next = acc_reg + prod_sh;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= LCG_SEED0;
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            seed_reg <= seed_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rnd  = seed_reg[30:16];

endmodule

`default_nettype wire

// ===== hdl/color_sweep_pattern_generator.sv =====
// Colour sweep frame generator: an accepted word is registered into the result registers and
// then into the output registers when the output is not stalled; in the random walk three
// generator updates (four multiplier digits plus hand-over each) come first and set the pace.
// A new word is taken only in the idle state, once the previous frame has been emitted.
// Reset restores step 8, walk length 256, phase 0, walk at 128 and the seed to 12345.
`timescale 1ns / 1ps
`default_nettype none

module color_sweep_pattern_generator (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         restart,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [15:0]       color,
    output logic [2:0]        phase_index,
    output logic              last_frame
);
    import csweep_pkg::*;

    cfg_t      cfg;
    lcg_stat_t lcg_stat;
    logic      lcg_start;

    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [8:0]  ramp_reg;
    logic [8:0]  ramp_next;
    logic [7:0]  wr_reg;
    logic [7:0]  wr_next;
    logic [7:0]  wg_reg;
    logic [7:0]  wg_next;
    logic [7:0]  wb_reg;
    logic [7:0]  wb_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [1:0]  ch_reg;
    logic [1:0]  ch_next;
    logic [15:0] res_color_reg;
    logic [15:0] res_color_next;
    logic [2:0]  res_phase_reg;
    logic [2:0]  res_phase_next;
    logic        res_last_reg;
    logic        res_last_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_color_reg;
    logic [2:0]  out_phase_reg;
    logic        out_last_reg;

    logic        accept;
    logic        go_walk;
    logic        emit_fire;
    logic [2:0]  eff_phase;
    logic [8:0]  eff_ramp;
    logic [7:0]  step_eff;
    logic [15:0] limit;
    logic [9:0]  ramp_sum;
    logic [7:0]  ramp_val;
    logic [2:0]  mask;
    logic [7:0]  cur_chan;
    logic [7:0]  new_chan;
    logic [15:0] cnt_inc;

    csweep_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csweep_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lcg_start),
        .stat  (lcg_stat)
    );

    assign accept    = in_valid & ~in_stall;
    assign eff_phase = restart ? PH_RED : phase_reg;
    assign eff_ramp  = restart ? 9'd0 : ramp_reg;
    assign go_walk   = (eff_phase == PH_WALK);
    assign step_eff  = (cfg.ramp_incr == 8'd0) ? 8'd1 : cfg.ramp_incr;
    assign limit     = (cfg.walk_frames == 16'd0) ? 16'd1 : cfg.walk_frames;
    assign ramp_sum  = {1'b0, eff_ramp} + {2'b0, step_eff};
    assign ramp_val  = (ramp_sum <= {2'b0, CHAN_MAX}) ? eff_ramp[7:0] : CHAN_MAX;
    assign mask      = phase_mask(eff_phase);
    assign new_chan  = walk_step(cur_chan, lcg_stat.rnd);
    assign cnt_inc   = count_reg + 16'd1;

    always_comb
    begin
        case (ch_reg)
            CH_RED:   cur_chan = wr_reg;
            CH_GREEN: cur_chan = wg_reg;
            CH_BLUE:  cur_chan = wb_reg;
            default:  cur_chan = wb_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = go_walk ? ST_RAND : ST_EMIT;
                end
            end
            ST_RAND:
            begin
                if (lcg_stat.done && ch_reg == CH_BLUE)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall  = 1'b1;
        lcg_start = 1'b0;
        emit_fire = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                lcg_start = in_valid & go_walk;
            end
            ST_RAND:
            begin
                lcg_start = lcg_stat.done & (ch_reg != CH_BLUE);
            end
            ST_EMIT:
            begin
                emit_fire = ~out_valid_reg | ~out_stall;
            end
            default: in_stall = 1'b1;
        endcase
    end

    // Frame datapath
    always_comb
    begin
        phase_next     = phase_reg;
        ramp_next      = ramp_reg;
        wr_next        = wr_reg;
        wg_next        = wg_reg;
        wb_next        = wb_reg;
        count_next     = count_reg;
        ch_next        = ch_reg;
        res_color_next = res_color_reg;
        res_phase_next = res_phase_reg;
        res_last_next  = res_last_reg;
        if (accept)
        begin
            if (restart)
            begin
                phase_next = PH_RED;
                ramp_next  = 9'd0;
                wr_next    = WALK_START;
                wg_next    = WALK_START;
                wb_next    = WALK_START;
                count_next = 16'd0;
            end
            if (go_walk)
            begin
                ch_next = CH_RED;
            end
            else
            begin
                if (ramp_sum <= {2'b0, CHAN_MAX})
                begin
                    ramp_next = ramp_sum[8:0];
                end
                else
                begin
                    ramp_next  = 9'd0;
                    phase_next = eff_phase + 3'd1;
                    if (eff_phase == PH_GREY)
                    begin
                        wr_next    = WALK_START;
                        wg_next    = WALK_START;
                        wb_next    = WALK_START;
                        count_next = 16'd0;
                    end
                end
                res_color_next = pack565(mask[2] ? ramp_val : 8'd0,
                                         mask[1] ? ramp_val : 8'd0,
                                         mask[0] ? ramp_val : 8'd0);
                res_phase_next = eff_phase;
                res_last_next  = 1'b0;
            end
        end
        else if (state_reg == ST_RAND && lcg_stat.done)
        begin
            case (ch_reg)
                CH_RED:   wr_next = new_chan;
                CH_GREEN: wg_next = new_chan;
                default:  wb_next = new_chan;
            endcase
            ch_next = ch_reg + 2'd1;
            if (ch_reg == CH_BLUE)
            begin
                res_color_next = pack565(wr_reg, wg_reg, new_chan);
                res_phase_next = PH_WALK;
                res_last_next  = (cnt_inc >= limit) || (cnt_inc == 16'd0);
                count_next     = cnt_inc;
                // Close the walk and go back to the red ramp
                if ((cnt_inc >= limit) || (cnt_inc == 16'd0))
                begin
                    phase_next = PH_RED;
                    ramp_next  = 9'd0;
                    wr_next    = WALK_START;
                    wg_next    = WALK_START;
                    wb_next    = WALK_START;
                    count_next = 16'd0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_RED;
            ramp_reg      <= 9'd0;
            wr_reg        <= WALK_START;
            wg_reg        <= WALK_START;
            wb_reg        <= WALK_START;
            count_reg     <= 16'd0;
            ch_reg        <= CH_RED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ramp_reg      <= ramp_next;
            wr_reg        <= wr_next;
            wg_reg        <= wg_next;
            wb_reg        <= wb_next;
            count_reg     <= count_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_color_reg <= res_color_next;
        res_phase_reg <= res_phase_next;
        res_last_reg  <= res_last_next;
        if (emit_fire)
        begin
            out_color_reg <= res_color_reg;
            out_phase_reg <= res_phase_reg;
            out_last_reg  <= res_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign color       = out_color_reg;
    assign phase_index = out_phase_reg;
    assign last_frame  = out_last_reg;

`ifndef SYNTH
    a_lcg_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_stat.busy |-> state_reg == ST_RAND)
        else $error("generator running outside the walk state");

    a_walk_ramp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WALK |-> ramp_reg == 9'd0)
        else $error("ramp not cleared during the walk");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised without an emit");

    a_last_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_frame |-> phase_index == PH_WALK)
        else $error("last frame flagged outside the walk");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for color_sweep_pattern_generator: frame colours and phases
// are predicted word by word and compared in order. Depends on csweep_pkg.
`timescale 1ns / 1ps

module tb;
    import csweep_pkg::*;

    localparam logic [31:0] LCG_MULT = 32'd1103515245;
    // Channel enables per ramp phase, three bits each, red phase lowest
    localparam logic [20:0] RAMP_ENABLES =
        {3'b111, 3'b011, 3'b101, 3'b110, 3'b001, 3'b010, 3'b100};
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_CHUNKS = 8;
    localparam int CHUNK_WORDS = 125;

    typedef struct packed {
        logic [15:0] rgb;
        logic [2:0]  phase;
        logic        last;
    } frame_t;

    class frame_checker;
        logic [7:0]  step_reg;
        logic [15:0] walk_reg;
        logic [2:0]  phase;
        logic [8:0]  ramp;
        logic [7:0]  walk_r;
        logic [7:0]  walk_g;
        logic [7:0]  walk_b;
        logic [15:0] walk_count;
        logic [31:0] seed;
        frame_t      due_frames[$];
        int          errors;

        function new();
            step_reg = RAMP_INCR_RST;
            walk_reg = WALK_FRAMES_RST;
            phase = PH_RED;
            ramp = '0;
            seed = LCG_SEED0;
            errors = 0;
            restart_walk();
        endfunction

        function void restart_walk();
            walk_r = WALK_START;
            walk_g = WALK_START;
            walk_b = WALK_START;
            walk_count = '0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_RAMP_INCR)
            begin
                step_reg = value[7:0];
            end
            else
            begin
                walk_reg = value[15:0];
            end
        endfunction

        function logic [7:0] walk_channel(logic [7:0] v);
            logic [14:0] rnd;
            int x;
            seed = seed * LCG_MULT + LCG_ADD;
            rnd = seed[30:16];
            x = int'(v) + int'(rnd % 15) - 7;
            if (x < 0)
            begin
                x = 0;
            end
            if (x > 255)
            begin
                x = 255;
            end
            return x[7:0];
        endfunction

        function void take_word(logic rs);
            frame_t f;
            logic [2:0] en;
            logic [8:0] step;
            logic [7:0] v;
            logic [15:0] lim;
            if (rs)
            begin
                phase = PH_RED;
                ramp = '0;
                restart_walk();
            end
            f.phase = phase;
            f.last = 1'b0;
            if (phase != PH_WALK)
            begin
                step = (step_reg == 8'd0) ? 9'd1 : {1'b0, step_reg};
                en = RAMP_ENABLES[3 * phase +: 3];
                if (ramp + step <= {1'b0, CHAN_MAX})
                begin
                    v = ramp[7:0];
                    ramp = ramp + step;
                end
                else
                begin
                    // top of the ramp: emit full scale and move on
                    v = CHAN_MAX;
                    ramp = '0;
                    if (phase == PH_GREY)
                    begin
                        restart_walk();
                    end
                    phase = phase + 3'd1;
                end
                f.rgb = {en[2] ? v[7:3] : 5'd0, en[1] ? v[7:2] : 6'd0,
                         en[0] ? v[7:3] : 5'd0};
            end
            else
            begin
                walk_r = walk_channel(walk_r);
                walk_g = walk_channel(walk_g);
                walk_b = walk_channel(walk_b);
                f.rgb = {walk_r[7:3], walk_g[7:2], walk_b[7:3]};
                walk_count = walk_count + 16'd1;
                lim = (walk_reg == 16'd0) ? 16'd1 : walk_reg;
                if (walk_count >= lim || walk_count == 16'd0)
                begin
                    f.last = 1'b1;
                    phase = PH_RED;
                    ramp = '0;
                    restart_walk();
                end
            end
            due_frames.push_back(f);
        endfunction

        function void check_frame(logic [15:0] rgb, logic [2:0] ph, logic last);
            frame_t f;
            if (due_frames.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("unexpected frame: color %h phase %0d last %b", rgb, ph, last);
                end
                return;
            end
            f = due_frames.pop_front();
            if (f.rgb !== rgb || f.phase !== ph || f.last !== last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("frame mismatch: expected color %h phase %0d last %b, got %h %0d %b",
                             f.rgb, f.phase, f.last, rgb, ph, last);
                end
            end
        endfunction

        function int pending();
            return due_frames.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] color;
    logic [2:0]  phase_index;
    logic        last_frame;

    int gap_pct = 0;
    int stall_pct = 0;
    frame_checker frames = new();

    color_sweep_pattern_generator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color       (color),
        .phase_index (phase_index),
        .last_frame  (last_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        if (out_valid && !out_stall)
        begin
            frames.check_frame(color, phase_index, last_frame);
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic send_word(input logic rs);
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        frames.take_word(rs);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Hold the input side until every frame due has come out
    task automatic drain_frames();
        in_valid <= 1'b0;
        while (frames.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int odds;
        logic [7:0] step_val;
        logic [15:0] walk_val;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings first, then the full sequence at the largest step
        send_word(1'b0);
        send_word(1'b1);
        drain_frames();
        reg_write(REG_RAMP_INCR, 32'd255);
        reg_write(REG_WALK_FRAMES, 32'd65535);
        send_word(1'b1);
        repeat (15) send_word(1'b0);
        // shorten the walk while inside it; zero length counts as one
        drain_frames();
        reg_write(REG_WALK_FRAMES, 32'd0);
        send_word(1'b0);
        send_word(1'b0);
        // change the step mid-ramp; zero step counts as one
        drain_frames();
        reg_write(REG_RAMP_INCR, 32'd0);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        drain_frames();

        for (int c = 0; c < RANDOM_CHUNKS; c++)
        begin
            case (c)
                1:
                begin
                    step_val = 8'd1;
                    walk_val = 16'd65535;
                end
                2:
                begin
                    step_val = 8'd255;
                    walk_val = 16'd1;
                end
                default:
                begin
                    case ($urandom_range(3))
                        0:       step_val = 8'($urandom_range(15, 1));
                        1:       step_val = 8'd255;
                        default: step_val = 8'($urandom_range(128, 16));
                    endcase
                    case ($urandom_range(4))
                        0:       walk_val = 16'd1;
                        1:       walk_val = 16'($urandom_range(65535, 256));
                        default: walk_val = 16'($urandom_range(48, 2));
                    endcase
                end
            endcase
            // junk above the register width must be dropped
            reg_write(REG_RAMP_INCR, {24'($urandom_range(16777215)), step_val});
            reg_write(REG_WALK_FRAMES, {16'($urandom), walk_val});
            case (c % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 62;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 62;
                end
                default:
                begin
                    gap_pct = 30;
                    stall_pct = 30;
                end
            endcase
            odds = (c == 3) ? 6 : 150;
            for (int i = 0; i < CHUNK_WORDS; i++)
            begin
                send_word($urandom_range(odds - 1) == 0);
            end
            drain_frames();
            stall_pct = 0;
        end

        drain_frames();
        repeat (40) @(posedge clk);
        if (frames.errors == 0 && frames.pending() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
